>>> sv/m68000_alu_with_condition_codes_assert.svh
// ----------------------------------------------------------------------------
// m68000_alu_with_condition_codes_assert.svh
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef M68000_ALU_WITH_CONDITION_CODES_ASSERT_SVH
`define M68000_ALU_WITH_CONDITION_CODES_ASSERT_SVH

// same-cycle implication
`define M68K_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("m68k_alu assertion failed");

// next-cycle implication
`define M68K_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("m68k_alu assertion failed");

`endif

>>> sv/m68k_alu_pkg.sv
// ----------------------------------------------------------------------------
// m68k_alu_pkg
// Types, operation codes and size helpers for the 68000-style ALU.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package m68k_alu_pkg;

   typedef enum logic [3:0] {
      ACT_ADD  = 4'd0,
      ACT_ADDX = 4'd1,
      ACT_AND  = 4'd2,
      ACT_ASL  = 4'd3,
      ACT_ASR  = 4'd4,
      ACT_CMP  = 4'd5,
      ACT_EOR  = 4'd6,
      ACT_LSL  = 4'd7,
      ACT_LSR  = 4'd8,
      ACT_OR   = 4'd9,
      ACT_ROL  = 4'd10,
      ACT_ROR  = 4'd11,
      ACT_ROXL = 4'd12,
      ACT_ROXR = 4'd13,
      ACT_SUB  = 4'd14,
      ACT_SUBX = 4'd15
   } action_type;

   typedef enum logic [1:0] {
      SIZE_BYTE = 2'd0,
      SIZE_WORD = 2'd1,
      SIZE_LONG = 2'd2,
      SIZE_ALT  = 2'd3
   } size_type;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   localparam int DATA_W  = 32;
   localparam int COUNT_W = 6;

   function automatic logic [DATA_W-1:0] size_mask(input size_type sz);
      logic [DATA_W-1:0] m;
      unique case (sz)
         SIZE_BYTE: m = 32'h0000_00ff;
         SIZE_WORD: m = 32'h0000_ffff;
         default:   m = 32'hffff_ffff;
      endcase
      return m;
   endfunction

   function automatic logic [DATA_W-1:0] size_msb(input size_type sz);
      logic [DATA_W-1:0] m;
      unique case (sz)
         SIZE_BYTE: m = 32'h0000_0080;
         SIZE_WORD: m = 32'h0000_8000;
         default:   m = 32'h8000_0000;
      endcase
      return m;
   endfunction

endpackage

>>> sv/m68k_alu_if.sv
// ----------------------------------------------------------------------------
// m68k_alu_if
// Request and response channels of the 68000-style ALU.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface m68k_alu_req_if;
   logic        valid;
   logic        ready;
   logic [3:0]  action;
   logic [1:0]  op_size;
   logic [31:0] source_operand;
   logic [31:0] target_operand;
   logic [5:0]  shift_count;

   modport source (output valid, action, op_size, source_operand, target_operand,
                   shift_count, input ready);
   modport sink   (input valid, action, op_size, source_operand, target_operand,
                   shift_count, output ready);
endinterface

interface m68k_alu_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] result_value;
   logic        flag_x;
   logic        flag_n;
   logic        flag_z;
   logic        flag_v;
   logic        flag_c;

   modport source (output valid, result_value, flag_x, flag_n, flag_z, flag_v, flag_c,
                   input ready);
   modport sink   (input valid, result_value, flag_x, flag_n, flag_z, flag_v, flag_c,
                   output ready);
endinterface

>>> sv/m68000_alu_with_condition_codes.sv
// ----------------------------------------------------------------------------
// m68000_alu_with_condition_codes
// 68000-style ALU and shifter keeping the X, N, Z, V and C flags.
// ----------------------------------------------------------------------------
// Add/sub/cmp/logic: a request beat loads the operand registers, then the
//   result and flags are registered into the response register. Shifts and
//   rotates first run the single-place shift step, one place per cycle.
// Request is not ready while an item is in work, so a new one waits for it.
// The response register lets the next request in while a result waits.
// Reset (synchronous, active high) clears all flags and the sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module m68000_alu_with_condition_codes (
   input logic             clock,
   input logic             reset,
   m68k_alu_req_if.sink    req_chan,
   m68k_alu_rsp_if.source  rsp_chan
);

   m68k_alu_pkg::state_type  state_ff, state_in;
   m68k_alu_pkg::action_type action_ff, action_in;
   m68k_alu_pkg::size_type   size_ff, size_in;
   logic [31:0] src_ff, src_in;
   logic [31:0] r_ff, r_in;
   logic        c_ff, c_in;
   logic        ov_ff, ov_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        cnt_zero_ff, cnt_zero_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] result_ff, result_in;
   logic        flag_x_ff, flag_x_in;
   logic        flag_n_ff, flag_n_in;
   logic        flag_z_ff, flag_z_in;
   logic        flag_v_ff, flag_v_in;
   logic        flag_c_ff, flag_c_in;

   logic        accept;
   logic [31:0] mask, msb_mask, req_mask;
   logic        is_shift, is_sub, is_left, ext_in;
   logic [32:0] sum;
   logic        carry_out;
   logic [31:0] arith_r;
   logic        in_bit, top_bit, step_c;
   logic [31:0] step_r;
   logic        done, finish;
   logic [31:0] fin_r;
   logic        fin_c, fin_v, fin_x, sticky;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= m68k_alu_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         flag_x_ff    <= 1'b0;
         flag_n_ff    <= 1'b0;
         flag_z_ff    <= 1'b0;
         flag_v_ff    <= 1'b0;
         flag_c_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         flag_x_ff    <= flag_x_in;
         flag_n_ff    <= flag_n_in;
         flag_z_ff    <= flag_z_in;
         flag_v_ff    <= flag_v_in;
         flag_c_ff    <= flag_c_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff   <= action_in;
      size_ff     <= size_in;
      src_ff      <= src_in;
      r_ff        <= r_in;
      c_ff        <= c_in;
      ov_ff       <= ov_in;
      cnt_ff      <= cnt_in;
      cnt_zero_ff <= cnt_zero_in;
      result_ff   <= result_in;
   end

   always_comb begin
      mask     = m68k_alu_pkg::size_mask(size_ff);
      msb_mask = m68k_alu_pkg::size_msb(size_ff);
      req_mask = m68k_alu_pkg::size_mask(m68k_alu_pkg::size_type'(req_chan.op_size));

      is_shift = !(action_ff inside {m68k_alu_pkg::ACT_ADD, m68k_alu_pkg::ACT_ADDX,
                                     m68k_alu_pkg::ACT_CMP, m68k_alu_pkg::ACT_SUB,
                                     m68k_alu_pkg::ACT_SUBX, m68k_alu_pkg::ACT_AND,
                                     m68k_alu_pkg::ACT_EOR, m68k_alu_pkg::ACT_OR});
      is_sub   = action_ff inside {m68k_alu_pkg::ACT_CMP, m68k_alu_pkg::ACT_SUB,
                                   m68k_alu_pkg::ACT_SUBX};
      ext_in   = flag_x_ff && (action_ff inside {m68k_alu_pkg::ACT_ADDX,
                                                 m68k_alu_pkg::ACT_SUBX});
      sticky   = action_ff inside {m68k_alu_pkg::ACT_ADDX, m68k_alu_pkg::ACT_SUBX};

      // shared adder
      if (is_sub) begin
         sum = {1'b0, r_ff} - {1'b0, src_ff} - {32'd0, ext_in};
      end else begin
         sum = {1'b0, r_ff} + {1'b0, src_ff} + {32'd0, ext_in};
      end
      unique case (size_ff)
         m68k_alu_pkg::SIZE_BYTE: carry_out = sum[8];
         m68k_alu_pkg::SIZE_WORD: carry_out = sum[16];
         default:                 carry_out = sum[32];
      endcase
      arith_r = sum[31:0] & mask;

      // single-place shift step
      top_bit = |(r_ff & msb_mask);
      is_left = action_ff inside {m68k_alu_pkg::ACT_ASL, m68k_alu_pkg::ACT_LSL,
                                  m68k_alu_pkg::ACT_ROL, m68k_alu_pkg::ACT_ROXL};
      case (action_ff) inside
         m68k_alu_pkg::ACT_ASR:                         in_bit = top_bit;
         m68k_alu_pkg::ACT_ROL:                         in_bit = top_bit;
         m68k_alu_pkg::ACT_ROR:                         in_bit = r_ff[0];
         m68k_alu_pkg::ACT_ROXL, m68k_alu_pkg::ACT_ROXR: in_bit = c_ff;
         default:                                       in_bit = 1'b0;
      endcase
      if (is_left) begin
         step_r = ((r_ff << 1) & mask) | {31'd0, in_bit};
         step_c = top_bit;
      end else begin
         step_r = (r_ff >> 1) | (in_bit ? msb_mask : 32'd0);
         step_c = r_ff[0];
      end

      // final result and flags
      fin_r = r_ff;
      fin_c = 1'b0;
      fin_v = 1'b0;
      fin_x = flag_x_ff;
      case (action_ff) inside
         m68k_alu_pkg::ACT_ADD, m68k_alu_pkg::ACT_ADDX, m68k_alu_pkg::ACT_SUB,
         m68k_alu_pkg::ACT_SUBX, m68k_alu_pkg::ACT_CMP: begin
            fin_r = arith_r;
            fin_c = carry_out;
            if (is_sub) begin
               fin_v = |((r_ff ^ src_ff) & (r_ff ^ arith_r) & msb_mask);
            end else begin
               fin_v = |(~(r_ff ^ src_ff) & (r_ff ^ arith_r) & msb_mask);
            end
            if (action_ff != m68k_alu_pkg::ACT_CMP) begin
               fin_x = carry_out;
            end
         end
         m68k_alu_pkg::ACT_AND: fin_r = r_ff & src_ff;
         m68k_alu_pkg::ACT_EOR: fin_r = r_ff ^ src_ff;
         m68k_alu_pkg::ACT_OR:  fin_r = r_ff | src_ff;
         default: begin
            fin_c = c_ff;
            if (action_ff == m68k_alu_pkg::ACT_ASL) begin
               fin_v = ov_ff;
            end
            if (action_ff inside {m68k_alu_pkg::ACT_ROXL, m68k_alu_pkg::ACT_ROXR}) begin
               fin_x = c_ff;
            end else if (!cnt_zero_ff && !(action_ff inside {m68k_alu_pkg::ACT_ROL,
                                                              m68k_alu_pkg::ACT_ROR})) begin
               fin_x = c_ff;
            end
         end
      endcase
   end

   always_comb begin
      req_chan.ready = (state_ff == m68k_alu_pkg::ST_IDLE);
      accept         = req_chan.valid && req_chan.ready;
      done           = !is_shift || (cnt_ff == 6'd0);
      finish         = (state_ff == m68k_alu_pkg::ST_RUN) && done &&
                       (!rsp_valid_ff || rsp_chan.ready);

      state_in     = state_ff;
      action_in    = action_ff;
      size_in      = size_ff;
      src_in       = src_ff;
      r_in         = r_ff;
      c_in         = c_ff;
      ov_in        = ov_ff;
      cnt_in       = cnt_ff;
      cnt_zero_in  = cnt_zero_ff;
      result_in    = result_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      flag_x_in    = flag_x_ff;
      flag_n_in    = flag_n_ff;
      flag_z_in    = flag_z_ff;
      flag_v_in    = flag_v_ff;
      flag_c_in    = flag_c_ff;

      unique case (state_ff)
         m68k_alu_pkg::ST_IDLE: begin
            if (accept) begin
               action_in   = m68k_alu_pkg::action_type'(req_chan.action);
               size_in     = m68k_alu_pkg::size_type'(req_chan.op_size);
               src_in      = req_chan.source_operand & req_mask;
               r_in        = req_chan.target_operand & req_mask;
               c_in        = flag_x_ff &&
                             ((req_chan.action == m68k_alu_pkg::ACT_ROXL) ||
                              (req_chan.action == m68k_alu_pkg::ACT_ROXR));
               ov_in       = 1'b0;
               cnt_in      = req_chan.shift_count;
               cnt_zero_in = (req_chan.shift_count == 6'd0);
               state_in    = m68k_alu_pkg::ST_RUN;
            end
         end
         m68k_alu_pkg::ST_RUN: begin
            if (!done) begin
               r_in   = step_r;
               c_in   = step_c;
               ov_in  = ov_ff | top_bit ^ (|(step_r & msb_mask));
               cnt_in = cnt_ff - 6'd1;
            end else if (finish) begin
               result_in    = fin_r;
               rsp_valid_in = 1'b1;
               flag_x_in    = fin_x;
               flag_n_in    = |(fin_r & msb_mask);
               flag_z_in    = (fin_r != 32'd0) ? 1'b0 : (sticky ? flag_z_ff : 1'b1);
               flag_v_in    = fin_v;
               flag_c_in    = fin_c;
               state_in     = m68k_alu_pkg::ST_IDLE;
            end
         end
         default: state_in = m68k_alu_pkg::ST_IDLE;
      endcase
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.result_value = result_ff;
   assign rsp_chan.flag_x       = flag_x_ff;
   assign rsp_chan.flag_n       = flag_n_ff;
   assign rsp_chan.flag_z       = flag_z_ff;
   assign rsp_chan.flag_v       = flag_v_ff;
   assign rsp_chan.flag_c       = flag_c_ff;

endmodule

>>> sv/m68k_alu_checker.sv
// ----------------------------------------------------------------------------
// m68k_alu_checker
// Port-level checks for the 68000-style ALU, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "m68000_alu_with_condition_codes_assert.svh"

module m68k_alu_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_result_value,
   input logic        rsp_flag_n,
   input logic        rsp_flag_z
);

   // hold a stalled response
   `M68K_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
                     rsp_valid && $stable(rsp_result_value))
   // busy after a request beat
   `M68K_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready)
   // nonzero result drops Z
   `M68K_ASSERT_IMPLY(a_zero_flag, clock, reset, rsp_valid && (rsp_result_value != 32'd0),
                      !rsp_flag_z)
   // negative result is never zero
   `M68K_ASSERT_IMPLY(a_neg_flag, clock, reset, rsp_valid && rsp_flag_n,
                      rsp_result_value != 32'd0)

endmodule

bind m68000_alu_with_condition_codes m68k_alu_checker u_m68k_alu_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_result_value (rsp_chan.result_value),
   .rsp_flag_n       (rsp_chan.flag_n),
   .rsp_flag_z       (rsp_chan.flag_z)
);
